// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the low-pass filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition that must never be seen at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ===== rtl/iirlp_pkg.sv =====
// Package with the constants, types and helpers of the fourth-order low-pass filter.
package iirlp_pkg;

	localparam int COEF_W = 40;
	localparam int OUT_W = 32;
	localparam int OUT_FRAC = 16;
	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int COEF_FRAC_DEF = 36;
	localparam int REG_IDX_W = 3;
	localparam int FB_PROD_W = COEF_W + OUT_W;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_NUM_OUTER  = 3'd0,
		REG_NUM_SECOND = 3'd1,
		REG_NUM_MIDDLE = 3'd2,
		REG_DEN_FIRST  = 3'd3,
		REG_DEN_SECOND = 3'd4,
		REG_DEN_THIRD  = 3'd5,
		REG_DEN_FOURTH = 3'd6
	} reg_idx_t;

	localparam logic signed [COEF_W-1:0] NUM_OUTER_RST  = 40'sd12740086;
	localparam logic signed [COEF_W-1:0] NUM_SECOND_RST = 40'sd50960346;
	localparam logic signed [COEF_W-1:0] NUM_MIDDLE_RST = 40'sd76440512;
	localparam logic signed [COEF_W-1:0] DEN_FIRST_RST  = -40'sd229802591974;
	localparam logic signed [COEF_W-1:0] DEN_SECOND_RST = 40'sd291292512653;
	localparam logic signed [COEF_W-1:0] DEN_THIRD_RST  = -40'sd165568780417;
	localparam logic signed [COEF_W-1:0] DEN_FOURTH_RST = 40'sd35560831093;

	typedef struct packed {
		logic load;
		logic adv;
	} pipe_ctl_t;

	// Accumulator width that holds nine exact products without overflow.
	function automatic int acc_width(input int sw);
		int prod_w;
		prod_w = (sw + OUT_FRAC > OUT_W) ? sw + OUT_FRAC : OUT_W;
		return COEF_W + prod_w + 4;
	endfunction

endpackage

// ===== rtl/iirlp_in_if.sv =====
// Sample channel interface with valid, ready and the raw sample.
interface iirlp_in_if #(
	parameter int SAMPLE_WIDTH = iirlp_pkg::SAMPLE_WIDTH_DEF
) ();
	logic valid;
	logic ready;
	logic signed [SAMPLE_WIDTH-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

// ===== rtl/iirlp_out_if.sv =====
// Result channel interface with valid, ready, the filtered value and the clip flag.
interface iirlp_out_if ();
	logic valid;
	logic ready;
	logic signed [iirlp_pkg::OUT_W-1:0] filtered;
	logic clipped;

	modport source (output valid, output filtered, output clipped, input ready);
	modport sink (input valid, input filtered, input clipped, output ready);
endinterface

// ===== rtl/iirlp_cell.sv =====
// One delay cell of the filter chain holding one past sample and one past output.
module iirlp_cell #(
	parameter int SAMPLE_WIDTH = iirlp_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  iirlp_pkg::pipe_ctl_t ctl,
	input  logic signed [SAMPLE_WIDTH-1:0] x_in,
	input  logic signed [iirlp_pkg::OUT_W-1:0] y_in,
	input  logic signed [iirlp_pkg::COEF_W-1:0] num_coef,
	input  logic signed [iirlp_pkg::COEF_W-1:0] den_coef,
	output logic signed [SAMPLE_WIDTH-1:0] x_q,
	output logic signed [iirlp_pkg::OUT_W-1:0] y_q,
	output logic signed [iirlp_pkg::acc_width(SAMPLE_WIDTH)-1:0] term
);
	localparam int ACC_W = iirlp_pkg::acc_width(SAMPLE_WIDTH);
	localparam int NUM_W = iirlp_pkg::COEF_W + SAMPLE_WIDTH;
	localparam int FB_W = iirlp_pkg::FB_PROD_W;
	localparam int NUM_EXT = ACC_W - NUM_W - iirlp_pkg::OUT_FRAC;

	logic signed [NUM_W-1:0] num_prod;
	logic signed [NUM_W-1:0] num_s1;
	logic signed [FB_W-1:0] fb_prod;
	logic signed [ACC_W-1:0] num_ext;
	logic signed [ACC_W-1:0] fb_ext;

	assign num_prod = num_coef * x_q;
	assign fb_prod = den_coef * y_q;
	assign num_ext = {{NUM_EXT{num_s1[NUM_W-1]}}, num_s1, {iirlp_pkg::OUT_FRAC{1'b0}}};
	assign fb_ext = {{(ACC_W-FB_W){fb_prod[FB_W-1]}}, fb_prod};
	assign term = num_ext - fb_ext;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			num_s1 <= num_prod;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
		end else begin
			if (ctl.load) begin
				x_q <= x_in;
			end
			if (ctl.adv) begin
				y_q <= y_in;
			end
		end
	end
endmodule

// ===== rtl/iirlp_head.sv =====
// Output stage: newest-sample term plus the cell terms, scaling, saturation and result register.
module iirlp_head #(
	parameter int SAMPLE_WIDTH = iirlp_pkg::SAMPLE_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = iirlp_pkg::COEF_FRAC_DEF
) (
	input  logic clk,
	input  iirlp_pkg::pipe_ctl_t ctl,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic signed [iirlp_pkg::COEF_W-1:0] num_coef,
	input  logic signed [iirlp_pkg::acc_width(SAMPLE_WIDTH)-1:0] term1,
	input  logic signed [iirlp_pkg::acc_width(SAMPLE_WIDTH)-1:0] term2,
	input  logic signed [iirlp_pkg::acc_width(SAMPLE_WIDTH)-1:0] term3,
	input  logic signed [iirlp_pkg::acc_width(SAMPLE_WIDTH)-1:0] term4,
	output logic signed [iirlp_pkg::OUT_W-1:0] y,
	output logic signed [iirlp_pkg::OUT_W-1:0] filtered_q,
	output logic clipped_q
);
	localparam int ACC_W = iirlp_pkg::acc_width(SAMPLE_WIDTH);
	localparam int NUM_W = iirlp_pkg::COEF_W + SAMPLE_WIDTH;
	localparam int OUT_W = iirlp_pkg::OUT_W;
	localparam int NUM_EXT = ACC_W - NUM_W - iirlp_pkg::OUT_FRAC;
	localparam int TOP_LO = COEF_FRAC_BITS + OUT_W - 1;

	logic signed [NUM_W-1:0] num_prod;
	logic signed [NUM_W-1:0] num_s1;
	logic signed [ACC_W-1:0] sum;
	logic [ACC_W-1-TOP_LO:0] top_bits;
	logic in_range;
	logic clip;

	assign num_prod = num_coef * sample;
	assign sum = ({{NUM_EXT{num_s1[NUM_W-1]}}, num_s1, {iirlp_pkg::OUT_FRAC{1'b0}}}
		+ (term1 + term2)) + (term3 + term4);
	assign top_bits = sum[ACC_W-1:TOP_LO];
	assign in_range = (&top_bits) || !(|top_bits);
	assign clip = !in_range;

	always_comb begin
		if (in_range) begin
			y = sum[TOP_LO:COEF_FRAC_BITS];
		end else if (sum[ACC_W-1]) begin
			y = {1'b1, {(OUT_W-1){1'b0}}};
		end else begin
			y = {1'b0, {(OUT_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			num_s1 <= num_prod;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			filtered_q <= y;
			clipped_q <= clip;
		end
	end
endmodule

// ===== rtl/iir_lowpass_order4_unit.sv =====
// Top level of the fourth-order IIR low-pass filter built as a chain of delay cells.
// Path: a sample transfer fills the product stage, then the chain update registers the result.
// Throughput: one sample per cycle while results are taken; the loop is the feedback multiply in each cell,
// the sum and saturation in the head, and the output history held in the cells.
// Reset clears both histories (every cell's sample and output to zero) and loads the default
// Butterworth set.
module iir_lowpass_order4_unit #(
	parameter int SAMPLE_WIDTH = iirlp_pkg::SAMPLE_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = iirlp_pkg::COEF_FRAC_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [iirlp_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [iirlp_pkg::COEF_W-1:0] wr_data,
	iirlp_in_if.sink sample_stream,
	iirlp_out_if.source result_stream
);
	`include "assert_macros.svh"

	localparam int ACC_W = iirlp_pkg::acc_width(SAMPLE_WIDTH);
	localparam int OUT_W = iirlp_pkg::OUT_W;

	logic signed [iirlp_pkg::COEF_W-1:0] num_outer_q, num_second_q, num_middle_q;
	logic signed [iirlp_pkg::COEF_W-1:0] den_coef_q [1:4];
	logic signed [iirlp_pkg::COEF_W-1:0] num_tap [1:4];
	logic signed [SAMPLE_WIDTH-1:0] x_tap [0:4];
	logic signed [OUT_W-1:0] y_tap [0:4];
	logic signed [ACC_W-1:0] term [1:4];
	logic signed [OUT_W-1:0] y;
	logic signed [OUT_W-1:0] filtered_q;
	logic clipped_q;
	logic valid_s1;
	logic out_valid_q;
	iirlp_pkg::pipe_ctl_t ctl;

	assign ctl.adv = valid_s1 && (!out_valid_q || result_stream.ready);
	assign sample_stream.ready = !valid_s1 || ctl.adv;
	assign ctl.load = sample_stream.valid && sample_stream.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_outer_q <= iirlp_pkg::NUM_OUTER_RST;
			num_second_q <= iirlp_pkg::NUM_SECOND_RST;
			num_middle_q <= iirlp_pkg::NUM_MIDDLE_RST;
			den_coef_q[1] <= iirlp_pkg::DEN_FIRST_RST;
			den_coef_q[2] <= iirlp_pkg::DEN_SECOND_RST;
			den_coef_q[3] <= iirlp_pkg::DEN_THIRD_RST;
			den_coef_q[4] <= iirlp_pkg::DEN_FOURTH_RST;
		end else if (wr_en) begin
			case (iirlp_pkg::reg_idx_t'(wr_index))
				iirlp_pkg::REG_NUM_OUTER: num_outer_q <= wr_data;
				iirlp_pkg::REG_NUM_SECOND: num_second_q <= wr_data;
				iirlp_pkg::REG_NUM_MIDDLE: num_middle_q <= wr_data;
				iirlp_pkg::REG_DEN_FIRST: den_coef_q[1] <= wr_data;
				iirlp_pkg::REG_DEN_SECOND: den_coef_q[2] <= wr_data;
				iirlp_pkg::REG_DEN_THIRD: den_coef_q[3] <= wr_data;
				iirlp_pkg::REG_DEN_FOURTH: den_coef_q[4] <= wr_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.load) begin
				valid_s1 <= 1'b1;
			end else if (ctl.adv) begin
				valid_s1 <= 1'b0;
			end
			if (ctl.adv) begin
				out_valid_q <= 1'b1;
			end else if (result_stream.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign num_tap[1] = num_second_q;
	assign num_tap[2] = num_middle_q;
	assign num_tap[3] = num_second_q;
	assign num_tap[4] = num_outer_q;
	assign x_tap[0] = sample_stream.sample;
	assign y_tap[0] = y;

	for (genvar k = 1; k <= 4; k++) begin : g_cell
		iirlp_cell #(
			.SAMPLE_WIDTH(SAMPLE_WIDTH)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl),
			.x_in(x_tap[k-1]),
			.y_in(y_tap[k-1]),
			.num_coef(num_tap[k]),
			.den_coef(den_coef_q[k]),
			.x_q(x_tap[k]),
			.y_q(y_tap[k]),
			.term(term[k])
		);
	end

	iirlp_head #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_head (
		.clk(clk),
		.ctl(ctl),
		.sample(sample_stream.sample),
		.num_coef(num_outer_q),
		.term1(term[1]),
		.term2(term[2]),
		.term3(term[3]),
		.term4(term[4]),
		.y(y),
		.filtered_q(filtered_q),
		.clipped_q(clipped_q)
	);

	assign result_stream.valid = out_valid_q;
	assign result_stream.filtered = filtered_q;
	assign result_stream.clipped = clipped_q;

	`ASSERT_AT(a_clip_at_bound, clk, arst_n, out_valid_q && clipped_q |-> (filtered_q == {1'b1, {(OUT_W-1){1'b0}}} || filtered_q == {1'b0, {(OUT_W-1){1'b1}}}), "clipped result is not at a bound")
	`ASSERT_NEVER(a_no_overwrite, clk, arst_n, ctl.load && valid_s1 && !ctl.adv, "sample transfer overwrote a waiting product stage")
	`ASSERT_AT(a_adv_gives_result, clk, arst_n, ctl.adv |=> out_valid_q, "chain update produced no result")
endmodule

// ===== test/tb_iir_lowpass_order4_unit.sv =====
// Testbench of the fourth-order IIR low-pass filter: checks every result against a bit-true prediction.
`timescale 1ns / 1ps

module tb_iir_lowpass_order4_unit;

	localparam int SW = iirlp_pkg::SAMPLE_WIDTH_DEF;
	localparam int CFB = iirlp_pkg::COEF_FRAC_DEF;
	localparam int IDX_W = iirlp_pkg::REG_IDX_W;
	localparam int CW = iirlp_pkg::COEF_W;
	localparam int OW = iirlp_pkg::OUT_W;
	localparam int ACC_W = 128;
	localparam int NUM_REGS = 7;
	localparam logic [IDX_W-1:0] REG_UNMAPPED = 3'd7;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 4;
	localparam int SEGMENT_ITEMS = 146;
	localparam logic signed [CW-1:0] COEF_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] COEF_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
	localparam logic signed [ACC_W-1:0] FILT_MAX_W = ACC_W'(64'sd2147483647);
	localparam logic signed [ACC_W-1:0] FILT_MIN_W = ACC_W'(-64'sd2147483648);

	typedef struct packed {
		logic signed [OW-1:0] filtered;
		logic clipped;
	} filt_out_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [IDX_W-1:0] wr_index;
	logic [CW-1:0] wr_data;

	iirlp_in_if #(.SAMPLE_WIDTH(SW)) sample_ch ();
	iirlp_out_if result_ch ();

	iir_lowpass_order4_unit #(
		.SAMPLE_WIDTH(SW),
		.COEF_FRAC_BITS(CFB)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.sample_stream(sample_ch.sink),
		.result_stream(result_ch.source)
	);

	logic signed [CW-1:0] coef_q [NUM_REGS];
	logic signed [SW-1:0] x_hist [4];
	logic signed [OW-1:0] y_hist [4];
	filt_out_t filtered_due [$];
	int fail_count = 0;
	int stall_count = 0;
	int src_idle_pct = 0;
	int sink_stall_pct = 0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic signed [ACC_W-1:0] wide_mul(input logic signed [CW-1:0] c,
			input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] cw;
		cw = ACC_W'(c);
		return cw * v;
	endfunction

	function automatic logic signed [CW-1:0] rand_coef(input int mag_bits);
		logic signed [63:0] r;
		r = {$urandom, $urandom};
		r = r >>> (64 - mag_bits);
		return r[CW-1:0];
	endfunction

	function automatic filt_out_t filter_step(input logic signed [SW-1:0] s);
		logic signed [ACC_W-1:0] xw [5];
		logic signed [ACC_W-1:0] acc;
		logic signed [ACC_W-1:0] sum_q;
		filt_out_t r;
		xw[0] = ACC_W'(s);
		for (int i = 0; i < 4; i++)
			xw[i+1] = ACC_W'(x_hist[i]);
		for (int i = 0; i < 5; i++)
			xw[i] = xw[i] <<< iirlp_pkg::OUT_FRAC;
		acc = wide_mul(coef_q[iirlp_pkg::REG_NUM_OUTER], xw[0])
			+ wide_mul(coef_q[iirlp_pkg::REG_NUM_SECOND], xw[1])
			+ wide_mul(coef_q[iirlp_pkg::REG_NUM_MIDDLE], xw[2])
			+ wide_mul(coef_q[iirlp_pkg::REG_NUM_SECOND], xw[3])
			+ wide_mul(coef_q[iirlp_pkg::REG_NUM_OUTER], xw[4])
			- wide_mul(coef_q[iirlp_pkg::REG_DEN_FIRST], ACC_W'(y_hist[0]))
			- wide_mul(coef_q[iirlp_pkg::REG_DEN_SECOND], ACC_W'(y_hist[1]))
			- wide_mul(coef_q[iirlp_pkg::REG_DEN_THIRD], ACC_W'(y_hist[2]))
			- wide_mul(coef_q[iirlp_pkg::REG_DEN_FOURTH], ACC_W'(y_hist[3]));
		sum_q = acc >>> CFB;
		if (sum_q > FILT_MAX_W) begin
			r.filtered = FILT_MAX_W[OW-1:0];
			r.clipped = 1'b1;
		end else if (sum_q < FILT_MIN_W) begin
			r.filtered = FILT_MIN_W[OW-1:0];
			r.clipped = 1'b1;
		end else begin
			r.filtered = sum_q[OW-1:0];
			r.clipped = 1'b0;
		end
		for (int i = 3; i > 0; i--) begin
			x_hist[i] = x_hist[i-1];
			y_hist[i] = y_hist[i-1];
		end
		x_hist[0] = s;
		y_hist[0] = r.filtered;
		return r;
	endfunction

	always @(posedge clk) begin
		filt_out_t want;
		if (sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1)
			filtered_due.push_back(filter_step(sample_ch.sample));
		if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (filtered_due.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%t: result transfer with nothing expected: filtered %0d clipped %0b",
						$realtime, result_ch.filtered, result_ch.clipped);
			end else begin
				want = filtered_due.pop_front();
				if (result_ch.filtered !== want.filtered || result_ch.clipped !== want.clipped) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%t: expected filtered %0d clipped %0b, got filtered %0d clipped %0b",
							$realtime, want.filtered, want.clipped, result_ch.filtered,
							result_ch.clipped);
				end
			end
		end
	end

	always @(posedge clk)
		result_ch.ready <= arst_n && ($urandom_range(99) >= sink_stall_pct);

	always @(posedge clk) begin
		if ((sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1)
				|| (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)) begin
			stall_count <= 0;
		end else begin
			stall_count <= stall_count + 1;
			if (stall_count >= WATCHDOG_LIMIT) begin
				$display("tb_iir_lowpass_order4_unit: FAIL");
				$finish;
			end
		end
	end

	task automatic send_sample(input logic signed [SW-1:0] s);
		while ($urandom_range(99) < src_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.sample <= s;
		@(posedge clk);
		while (sample_ch.ready !== 1'b1)
			@(posedge clk);
	endtask

	task automatic settle();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (filtered_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CW-1:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		if (idx < NUM_REGS)
			coef_q[idx] = val;
		@(posedge clk);
	endtask

	task automatic program_coefs(input logic signed [CW-1:0] coef_set [NUM_REGS]);
		settle();
		for (int i = 0; i < NUM_REGS; i++)
			write_reg(IDX_W'(i), coef_set[i]);
		wr_en <= 1'b0;
	endtask

	task automatic restore_reset_coefs();
		logic signed [CW-1:0] coef_set [NUM_REGS];
		coef_set[iirlp_pkg::REG_NUM_OUTER] = iirlp_pkg::NUM_OUTER_RST;
		coef_set[iirlp_pkg::REG_NUM_SECOND] = iirlp_pkg::NUM_SECOND_RST;
		coef_set[iirlp_pkg::REG_NUM_MIDDLE] = iirlp_pkg::NUM_MIDDLE_RST;
		coef_set[iirlp_pkg::REG_DEN_FIRST] = iirlp_pkg::DEN_FIRST_RST;
		coef_set[iirlp_pkg::REG_DEN_SECOND] = iirlp_pkg::DEN_SECOND_RST;
		coef_set[iirlp_pkg::REG_DEN_THIRD] = iirlp_pkg::DEN_THIRD_RST;
		coef_set[iirlp_pkg::REG_DEN_FOURTH] = iirlp_pkg::DEN_FOURTH_RST;
		program_coefs(coef_set);
	endtask

	task automatic test_default_response();
		send_sample(SAMPLE_MAX);
		repeat (4) send_sample('0);
		send_sample(SAMPLE_MIN);
		repeat (2) send_sample('0);
	endtask

	task automatic test_saturation();
		logic signed [CW-1:0] coef_set [NUM_REGS];
		for (int i = 0; i < NUM_REGS; i++)
			coef_set[i] = '0;
		coef_set[iirlp_pkg::REG_NUM_OUTER] = COEF_MAX;
		program_coefs(coef_set);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		send_sample(SAMPLE_MAX);
		send_sample(SW'(1));
		for (int i = 0; i < NUM_REGS; i++)
			coef_set[i] = COEF_MIN;
		program_coefs(coef_set);
		send_sample(SW'(1));
		send_sample(SW'(-1));
		send_sample('0);
		send_sample(SAMPLE_MAX);
	endtask

	task automatic test_unstable_feedback();
		restore_reset_coefs();
		settle();
		write_reg(iirlp_pkg::REG_DEN_FIRST, COEF_MIN);
		wr_en <= 1'b0;
		send_sample(SW'(100));
		repeat (4) send_sample('0);
	endtask

	task automatic test_unmapped_index();
		restore_reset_coefs();
		settle();
		write_reg(REG_UNMAPPED, {$urandom, $urandom});
		wr_en <= 1'b0;
		send_sample(SAMPLE_MIN);
		send_sample(SAMPLE_MAX);
		send_sample(SW'(12345));
	endtask

	task automatic test_random_phase(input int src_pct, input int sink_pct);
		logic signed [CW-1:0] coef_set [NUM_REGS];
		logic signed [SW-1:0] s;
		src_idle_pct = src_pct;
		sink_stall_pct = sink_pct;
		for (int seg = 0; seg < 4; seg++) begin
			case ($urandom_range(5))
				0: restore_reset_coefs();
				1: begin
					for (int i = 0; i < NUM_REGS; i++)
						coef_set[i] = rand_coef(CW);
					program_coefs(coef_set);
				end
				default: begin
					// Feedback magnitudes sum below one, so the filter stays stable.
					coef_set[iirlp_pkg::REG_NUM_OUTER] = rand_coef(31);
					coef_set[iirlp_pkg::REG_NUM_SECOND] = rand_coef(32);
					coef_set[iirlp_pkg::REG_NUM_MIDDLE] = rand_coef(33);
					coef_set[iirlp_pkg::REG_DEN_FIRST] = rand_coef(35);
					coef_set[iirlp_pkg::REG_DEN_SECOND] = rand_coef(34);
					coef_set[iirlp_pkg::REG_DEN_THIRD] = rand_coef(33);
					coef_set[iirlp_pkg::REG_DEN_FOURTH] = rand_coef(32);
					program_coefs(coef_set);
				end
			endcase
			for (int n = 0; n < SEGMENT_ITEMS; n++) begin
				case ($urandom_range(9))
					0: s = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
					1, 2: s = SW'($urandom_range(512) - 256);
					default: s = SW'($urandom);
				endcase
				send_sample(s);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.sample = '0;
		result_ch.ready = 1'b0;
		coef_q[iirlp_pkg::REG_NUM_OUTER] = iirlp_pkg::NUM_OUTER_RST;
		coef_q[iirlp_pkg::REG_NUM_SECOND] = iirlp_pkg::NUM_SECOND_RST;
		coef_q[iirlp_pkg::REG_NUM_MIDDLE] = iirlp_pkg::NUM_MIDDLE_RST;
		coef_q[iirlp_pkg::REG_DEN_FIRST] = iirlp_pkg::DEN_FIRST_RST;
		coef_q[iirlp_pkg::REG_DEN_SECOND] = iirlp_pkg::DEN_SECOND_RST;
		coef_q[iirlp_pkg::REG_DEN_THIRD] = iirlp_pkg::DEN_THIRD_RST;
		coef_q[iirlp_pkg::REG_DEN_FOURTH] = iirlp_pkg::DEN_FOURTH_RST;
		for (int i = 0; i < 4; i++) begin
			x_hist[i] = '0;
			y_hist[i] = '0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_default_response();
		test_saturation();
		test_unstable_feedback();
		test_unmapped_index();
		test_random_phase(17, 52);
		test_random_phase(52, 17);
		test_random_phase(0, 0);
		settle();
		if (fail_count == 0)
			$display("tb_iir_lowpass_order4_unit: PASS");
		else
			$display("tb_iir_lowpass_order4_unit: FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/iirlp_pkg.sv
rtl/iirlp_in_if.sv
rtl/iirlp_out_if.sv
rtl/iirlp_cell.sv
rtl/iirlp_head.sv
rtl/iir_lowpass_order4_unit.sv
test/tb_iir_lowpass_order4_unit.sv
